@@ rtl/core/hbs_pkg.sv @@
// shared constants and types for the bucketed hash set
package hbs_pkg;

	localparam int KEY_W  = 31;
	localparam int SLOT_W = KEY_W + 1;	// valid bit above the key
	localparam int ACT_W  = 2;

	localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TEST   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	typedef struct packed {
		logic was_present;
		logic refused;
	} row_res_t;

endpackage

@@ rtl/core/hbs_ram.sv @@
// generic single-write, single-read ram with registered read data
module hbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/hbs_mod.sv @@
// key modulo bucket count by reciprocal multiply and one correction-free subtract
module hbs_mod #(
	parameter int NUM_BUCKETS = 10
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic [hbs_pkg::KEY_W-1:0] key,
	output logic [hbs_pkg::KEY_W-1:0] key_held,
	output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);
	import hbs_pkg::*;

	localparam int LOG_N = $clog2(NUM_BUCKETS);
	localparam int BW    = (NUM_BUCKETS > 1) ? LOG_N : 1;
	localparam int SHIFT = KEY_W + LOG_N;
	localparam int MUL_W = 32;
	localparam int PROD_W = KEY_W + MUL_W;
	localparam logic [63:0] MAGIC_64 = ((64'd1 << SHIFT) / NUM_BUCKETS) + 64'd1;
	localparam logic [MUL_W-1:0] MAGIC = MAGIC_64[MUL_W-1:0];

	logic [PROD_W-1:0] prod_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [KEY_W-1:0]  quot;
	logic [KEY_W-1:0]  rem;

	// floor(key * magic / 2^shift) is exact for every 31-bit key
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(key) * PROD_W'(MAGIC);
			key_s1  <= key;
		end
	end

	always_comb begin
		quot = KEY_W'(prod_s1 >> SHIFT);
		rem  = key_s1 - KEY_W'(quot * KEY_W'(NUM_BUCKETS));
	end

	assign bucket   = rem[BW-1:0];
	assign key_held = key_s1;

endmodule

@@ rtl/core/hbs_row.sv @@
// search and update of one bucket row
module hbs_row #(
	parameter int SLOTS = 8
) (
	input  logic [hbs_pkg::ACT_W-1:0]         action,
	input  logic [hbs_pkg::KEY_W-1:0]         key,
	input  logic                              row_live,
	input  logic [SLOTS*hbs_pkg::SLOT_W-1:0]  row,
	output logic [SLOTS*hbs_pkg::SLOT_W-1:0]  new_row,
	output hbs_pkg::row_res_t                 res
);
	import hbs_pkg::*;

	logic [SLOTS-1:0] vld;
	logic [SLOTS-1:0] match;
	logic [SLOTS-1:0] free;
	logic [SLOTS-1:0] first_free;
	logic [SLOTS-1:0] new_vld;
	logic             hit;
	logic             full;
	logic             do_add;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			vld[s]   = row_live & row[s*SLOT_W + KEY_W];
			match[s] = vld[s] && (row[s*SLOT_W +: KEY_W] == key);
		end
		hit        = |match;
		free       = ~vld;
		full       = ~|free;
		first_free = free & (~free + SLOTS'(1));
		do_add     = (action == ACT_ADD) && !hit && !full;

		case (action)
			ACT_ADD:    new_vld = do_add ? (vld | first_free) : vld;
			ACT_REMOVE: new_vld = vld & ~match;
			default:    new_vld = vld;
		endcase

		for (int s = 0; s < SLOTS; s++) begin
			new_row[s*SLOT_W + KEY_W] = new_vld[s];
			new_row[s*SLOT_W +: KEY_W] = (do_add && first_free[s]) ? key
				: row[s*SLOT_W +: KEY_W];
		end

		res.was_present = hit;
		res.refused     = (action == ACT_ADD) && !hit && full;
	end

endmodule

@@ rtl/core/bucketed_hash_set_top.sv @@
// top level of the bucketed hash set: control, row-valid flags, result registers
// the result strobe (done) is registered from the update state, which follows the row read state of the request
// a new request can be taken during the write-back of the previous one; busy is high for the one cycle of the row read
// the ram row read of the next request follows the write-back of the previous one, so no forwarding
// reset: arst_n clears control and all row-written flags, so the set is empty at once
// the receiver cannot stall; done is high for exactly one cycle per request
module bucketed_hash_set_top #(
	parameter int NUM_BUCKETS      = 10,
	parameter int SLOTS_PER_BUCKET = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [hbs_pkg::ACT_W-1:0] action,
	input  logic [hbs_pkg::KEY_W-1:0] key,
	output logic                      done,
	output logic                      was_present,
	output logic                      status
);
	import hbs_pkg::*;

	localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int ROW_W = SLOTS_PER_BUCKET * SLOT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} state_t;

	state_t            state_q;
	logic              accept;
	logic [ACT_W-1:0]  action_s1;
	logic [KEY_W-1:0]  key_held;
	logic [BW-1:0]     bucket;
	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  wr_row;
	logic [NUM_BUCKETS-1:0] row_init_q;
	logic              row_live;
	logic              done_q;
	logic              was_present_q;
	logic              status_q;
	row_res_t          res;

	// a request is taken in idle or during the write-back of the previous one
	assign busy   = (state_q == ST_READ);
	assign accept = start && !busy;

	// bucket index: product registered at the accept edge, reduction in the read cycle
	hbs_mod #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_mod (
		.clk      (clk),
		.load     (accept),
		.key      (key),
		.key_held (key_held),
		.bucket   (bucket)
	);

	// one row per bucket: each slot is {valid, key}
	hbs_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_BUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (state_q == ST_UPDATE),
		.waddr (bucket),
		.wdata (wr_row),
		.re    (state_q == ST_READ),
		.raddr (bucket),
		.rdata (rd_row)
	);

	// rows never written read as empty, whatever the ram holds
	assign row_live = row_init_q[bucket];

	hbs_row #(
		.SLOTS(SLOTS_PER_BUCKET)
	) u_row (
		.action   (action_s1),
		.key      (key_held),
		.row_live (row_live),
		.row      (rd_row),
		.new_row  (wr_row),
		.res      (res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
		end
		if (state_q == ST_UPDATE) begin
			was_present_q <= res.was_present;
			status_q      <= res.refused;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			row_init_q <= '0;
		end else begin
			done_q <= (state_q == ST_UPDATE);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					// whole row is written back, so the row now holds real valid bits
					row_init_q[bucket] <= 1'b1;
					state_q <= accept ? ST_READ : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign was_present = was_present_q;
	assign status      = status_q;

endmodule
